[rtl/bofn_pkg.sv]
// ----------------------------------------------------------------------------
// bofn_pkg
// Types and constants shared by the four-neighbor binary outline unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bofn_pkg;

    // Width of a configuration register and its write data.
    localparam int unsigned CFG_W = 10;

    // Request opcodes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Entries in the result queue.
    localparam int unsigned RES_DEPTH = 3;

    typedef struct packed {
        logic opcode;
        logic mask_bit;
    } item_t;

    typedef struct packed {
        logic outline_bit;
        logic last_of_frame;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
    } res_status_t;

endpackage : bofn_pkg

`default_nettype wire

[rtl/bofn_row_ram.sv]
// ----------------------------------------------------------------------------
// bofn_row_ram
// One-bit line buffer with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bofn_row_ram #(
    parameter int unsigned DEPTH  = 512,
    parameter int unsigned ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic              wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic                   rd_data
);

    logic mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule : bofn_row_ram

`default_nettype wire

[rtl/bofn_result_fifo.sv]
// ----------------------------------------------------------------------------
// bofn_result_fifo
// Small result queue that decouples the outline pipeline from the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module bofn_result_fifo
    import bofn_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         result_valid,
    input  wire logic    result_ready,
    output result_t      result,
    output res_status_t  status
);

    result_t    entry_reg [RES_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign result       = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && result_ready;
    assign status.count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == 2'(RES_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == 2'(RES_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : bofn_result_fifo

`default_nettype wire

[rtl/binary_outline_four_neighbor_unit.sv]
// Release: the result of a pixel is released by the request that comes frame_width + 1
// counted requests later (ignored requests do not count), which pushes it from the
// pipeline stage into the result queue.
// Throughput: one request per cycle while item_ready is high; each counted request does
// one read and one write of each row buffer; the three-entry queue absorbs consumer stalls.
// Reset: counters, pipeline and queue clear at once; the row buffers are not cleared.
// ----------------------------------------------------------------------------
// binary_outline_four_neighbor_unit
// Streams a binary mask in raster order and flags set pixels that lie on the
// frame border or have an unset four-neighbor, using two line buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_outline_four_neighbor_unit
    import bofn_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 512
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire item_t            item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output result_t               result,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int unsigned COL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SIDE + 2);

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             compute;
        logic             border;
        logic             last;
        logic             mask;
    } stage_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W-1:0] height_eff;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] col_ext;

    logic             accept;
    logic             draining;
    logic             is_drain;
    logic             take;
    logic             mask_eff;
    logic [COL_W-1:0] right_addr;
    stage_t           s0;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    stage_t           s1_reg;

    logic             self_rd;
    logic             right_rd;
    logic             up_rd;
    logic             up_val;
    logic             up_fwd_reg;
    logic             up_fwd_data_reg;
    logic             left_reg;
    logic             outline;

    logic             held_valid_reg;
    logic             held_bit_reg;
    logic             held_last_reg;
    logic             push;
    result_t          push_data;
    res_status_t      res_status;

    // Out-of-range sizes act as the nearest legal size.
    function automatic logic [CNT_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
        begin
            return CNT_W'(1);
        end
        else if (v32 > 32'(MAX_SIDE))
        begin
            return CNT_W'(MAX_SIDE);
        end
        return CNT_W'(v32);
    endfunction

    assign width_eff  = clamp_side(width_reg);
    assign height_eff = clamp_side(height_reg);

    // Room for the result that the pipeline stage may still push.
    assign item_ready = ({1'b0, res_status.count} + {2'b00, s1_valid_reg}) < 3'(RES_DEPTH);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        draining   = (row_reg >= height_eff);
        is_drain   = (item.opcode == OP_DRAIN);
        take       = accept && (is_drain == draining);
        mask_eff   = item.mask_bit && !is_drain;
        col_ext    = CNT_W'(col_reg);
        right_addr = (32'(col_reg) == 32'(MAX_SIDE - 1)) ? '0 : col_reg + COL_W'(1);

        s0.col     = col_reg;
        s0.mask    = mask_eff;
        s0.compute = (row_reg != '0) && (row_reg <= height_eff);
        s0.border  = (row_reg == CNT_W'(1)) || (row_reg == height_eff) ||
                     (col_reg == '0) || (col_ext == width_eff - CNT_W'(1));
        s0.last    = (row_reg == height_eff) && (col_ext == width_eff - CNT_W'(1));

        fill_inc   = draining ? fill_reg + CNT_W'(1) : fill_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        fill_next  = fill_reg;
        if (cfg_write)
        begin
            col_next  = '0;
            row_next  = '0;
            fill_next = '0;
        end
        else if (take)
        begin
            fill_next = fill_inc;
            if (col_ext + CNT_W'(1) >= width_eff)
            begin
                col_next = '0;
                row_next = row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
            // The final drain request closes the frame.
            if (draining && (fill_inc >= width_eff + CNT_W'(1)))
            begin
                col_next  = '0;
                row_next  = '0;
                fill_next = '0;
            end
        end
        s1_valid_next = take && !cfg_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= CFG_W'(1);
            height_reg     <= CFG_W'(1);
            col_reg        <= '0;
            row_reg        <= '0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          width_reg  <= width_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            fill_reg     <= fill_next;
            s1_valid_reg <= s1_valid_next;
            if (cfg_write)
            begin
                held_valid_reg <= 1'b0;
            end
            else if (s1_valid_reg)
            begin
                held_valid_reg <= s1_reg.compute;
            end
        end
    end

    // Center row: two copies so that the pixel and its right neighbor read together.
    bofn_row_ram #(
        .DEPTH  (MAX_SIDE),
        .ADDR_W (COL_W)
    ) u_center_a (
        .clk     (clk),
        .wr_en   (take),
        .wr_addr (col_reg),
        .wr_data (mask_eff),
        .rd_addr (col_reg),
        .rd_data (self_rd)
    );

    bofn_row_ram #(
        .DEPTH  (MAX_SIDE),
        .ADDR_W (COL_W)
    ) u_center_b (
        .clk     (clk),
        .wr_en   (take),
        .wr_addr (col_reg),
        .wr_data (mask_eff),
        .rd_addr (right_addr),
        .rd_data (right_rd)
    );

    // Upper row takes the old center value once it has been read.
    bofn_row_ram #(
        .DEPTH  (MAX_SIDE),
        .ADDR_W (COL_W)
    ) u_upper (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_reg.col),
        .wr_data (self_rd),
        .rd_addr (col_reg),
        .rd_data (up_rd)
    );

    // When consecutive requests hit the same column, the upper row write is
    // still in flight, so its data is forwarded.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= s0;
        end
        up_fwd_reg      <= s1_valid_reg && (s1_reg.col == col_reg);
        up_fwd_data_reg <= self_rd;
        if (s1_valid_reg)
        begin
            left_reg      <= self_rd;
            held_bit_reg  <= outline;
            held_last_reg <= s1_reg.last;
        end
    end

    assign up_val  = up_fwd_reg ? up_fwd_data_reg : up_rd;
    assign outline = self_rd && (s1_reg.border || !right_rd || !left_reg ||
                                 !s1_reg.mask || !up_val);

    // The held result goes out when the next request is processed.
    assign push                    = s1_valid_reg && held_valid_reg;
    assign push_data.outline_bit   = held_bit_reg;
    assign push_data.last_of_frame = held_last_reg;

    bofn_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .status       (res_status)
    );

endmodule : binary_outline_four_neighbor_unit

`default_nettype wire

[rtl/bofn_checker.sv]
// ----------------------------------------------------------------------------
// bofn_checker
// Port-level checks for the four-neighbor binary outline unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bofn_checker
    import bofn_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    // A stalled result keeps its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Requests are refused only while results are waiting.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("request refused with no result pending");

    // A result appears only after an accepted request has passed the pipeline stage.
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a preceding request");

endmodule : bofn_checker

bind binary_outline_four_neighbor_unit bofn_checker u_bofn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

[verif/tb_binary_outline_four_neighbor_unit.sv]
// ----------------------------------------------------------------------------
// tb_binary_outline_four_neighbor_unit
// Streams binary masks through the outline unit in raster order. The mask is
// followed by the drain ticks that flush it. A line-buffer predictor works out
// every outline bit and end-of-frame flag, and the results are checked in
// order. Both handshakes idle at random. Directed frames come first, then
// extreme frame sizes, then random frames with ignored and abandoned requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_binary_outline_four_neighbor_unit;
    import bofn_pkg::*;

    localparam int unsigned SIDE_LIMIT = 512;
    localparam int CLK_PERIOD = 10;
    localparam int RANDOM_REQUESTS = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    item_t request_item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_write = 1'b0;
    logic cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    // Predictor state: registers, line buffers, frame position and the
    // outline result that waits for the next request to release it.
    logic [CFG_W-1:0] frame_w_reg;
    logic [CFG_W-1:0] frame_h_reg;
    logic upper_line [0:SIDE_LIMIT-1];
    logic center_line [0:SIDE_LIMIT-1];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned drain_count;
    logic pending_valid;
    result_t pending_result;
    result_t outline_expect [$];

    bit source_pacing = 1'b1;
    bit sink_stalls = 1'b1;
    int error_count = 0;
    int results_checked = 0;
    int frames_done = 0;
    int effective_requests = 0;
    int quiet_cycles = 0;

    binary_outline_four_neighbor_unit #(
        .MAX_SIDE(SIDE_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(request_item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned side_of(input logic [CFG_W-1:0] raw);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > SIDE_LIMIT)
        begin
            return SIDE_LIMIT;
        end
        return 32'(raw);
    endfunction

    function automatic void clear_frame_position();
        col_pos = 0;
        row_pos = 0;
        drain_count = 0;
        pending_valid = 1'b0;
        pending_result = '0;
    endfunction

    function automatic void predict_outline(input logic op, input logic px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned pr;
        logic draining;
        logic pix;
        logic v;
        w = side_of(frame_w_reg);
        h = side_of(frame_h_reg);
        draining = (row_pos >= h);
        // Drain ticks while pixels are due, and pixels during the drain, are dropped.
        if ((op == OP_DRAIN) != draining)
        begin
            return;
        end
        effective_requests++;
        pix = (op == OP_DRAIN) ? 1'b0 : px;
        c = (col_pos >= w) ? w - 1 : col_pos;
        if (pending_valid)
        begin
            outline_expect.push_back(pending_result);
            pending_valid = 1'b0;
        end
        // The pixel one row above this request now has all four neighbors known.
        if (row_pos >= 1 && row_pos - 1 < h)
        begin
            pr = row_pos - 1;
            v = 1'b0;
            if (center_line[c])
            begin
                if (pr == 0 || pr == h - 1 || c == 0 || c == w - 1)
                begin
                    v = 1'b1;
                end
                else
                begin
                    v = !center_line[c + 1] || !upper_line[c - 1] || !pix || !upper_line[c];
                end
            end
            pending_result.outline_bit = v;
            pending_result.last_of_frame = (pr == h - 1 && c == w - 1);
            pending_valid = 1'b1;
        end
        upper_line[c] = center_line[c];
        center_line[c] = pix;
        if (draining)
        begin
            drain_count++;
        end
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (draining && drain_count >= w + 1)
        begin
            clear_frame_position();
        end
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    task automatic send_request(input logic op, input logic px);
        int gap;
        item_t req;
        gap = source_pacing ? pick_gap() : 0;
        req.opcode = op;
        req.mask_bit = px;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        request_item <= req;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        predict_outline(op, px);
    endtask

    task automatic wait_until_idle();
        item_valid <= 1'b0;
        while (outline_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        wait_until_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w_raw;
        @(posedge clk);
        frame_w_reg = w_raw;
        clear_frame_position();
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h_raw;
        @(posedge clk);
        frame_h_reg = h_raw;
        clear_frame_position();
        cfg_write <= 1'b0;
    endtask

    // Streams one frame at the current size, then its drain ticks. A stop point
    // of zero or more abandons the frame after that many counted requests.
    task automatic run_frame(input int density, input int noise_pct, input int stop_at);
        int w;
        int pixels;
        int sent;
        w = side_of(frame_w_reg);
        pixels = w * side_of(frame_h_reg);
        for (sent = 0; sent < pixels + w + 1; sent++)
        begin
            if (stop_at >= 0 && sent == stop_at)
            begin
                return;
            end
            if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
            begin
                send_request((sent < pixels) ? OP_DRAIN : OP_PIXEL, 1'($urandom_range(0, 1)));
            end
            if (sent < pixels)
            begin
                send_request(OP_PIXEL, $urandom_range(0, 99) < density);
            end
            else
            begin
                send_request(OP_DRAIN, 1'($urandom_range(0, 1)));
            end
        end
        frames_done++;
    endtask

    // The reset size is a single pixel; stray drains and pixels are dropped.
    task automatic test_defaults_after_reset();
        send_request(OP_DRAIN, 1'b1);
        send_request(OP_PIXEL, 1'b1);
        send_request(OP_PIXEL, 1'b0);
        send_request(OP_DRAIN, 1'b0);
        send_request(OP_DRAIN, 1'b1);
        send_request(OP_PIXEL, 1'b0);
        send_request(OP_DRAIN, 1'b0);
        send_request(OP_DRAIN, 1'b0);
        frames_done += 2;
    endtask

    // A solid 3x3 block: only the middle pixel has all four neighbors set.
    task automatic test_interior_pixel();
        write_frame_size(3, 3);
        run_frame(100, 0, -1);
    endtask

    // Zero acts as one and values past the largest side are clamped to it.
    // The wide frame is cut off part way through its drain once the row
    // wrap at the largest side has been seen.
    task automatic test_size_extremes();
        write_frame_size(0, 0);
        run_frame(100, 0, -1);
        write_frame_size(1023, 1);
        run_frame(70, 2, SIDE_LIMIT + 100);
        write_frame_size(0, 1023);
        run_frame(70, 2, -1);
    endtask

    task automatic test_random_frames();
        int start;
        int w_raw;
        int h_raw;
        int w;
        int h;
        int stop_at;
        int noise_pct;
        bit need_write;
        start = effective_requests;
        need_write = 1'b1;
        w_raw = 1;
        h_raw = 1;
        while (effective_requests - start < RANDOM_REQUESTS)
        begin
            source_pacing = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if (need_write || $urandom_range(0, 99) >= 35)
            begin
                case ($urandom_range(0, 19))
                    0: w_raw = 0;
                    1, 2, 3: w_raw = $urandom_range(9, 40);
                    default: w_raw = $urandom_range(1, 8);
                endcase
                h_raw = ($urandom_range(0, 19) == 0) ? 0 :
                        ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                write_frame_size(CFG_W'(w_raw), CFG_W'(h_raw));
            end
            w = side_of(CFG_W'(w_raw));
            h = side_of(CFG_W'(h_raw));
            noise_pct = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(2, 8);
            stop_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, w * h + w) : -1;
            case ($urandom_range(0, 3))
                0: run_frame(15, noise_pct, stop_at);
                1: run_frame(50, noise_pct, stop_at);
                default: run_frame(90, noise_pct, stop_at);
            endcase
            // A cut-off frame leaves the block mid-stream until the size is rewritten.
            need_write = (stop_at >= 0);
        end
        source_pacing = 1'b1;
        sink_stalls = 1'b1;
        wait_until_idle();
    endtask

    initial
    begin : sink_pacing
        int stall;
        forever
        begin
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            stall = sink_stalls ? pick_gap() : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (outline_expect.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected result, expected none, actual outline=%0b last=%0b",
                             $time, result.outline_bit, result.last_of_frame);
                end
            end
            else
            begin
                if (result.outline_bit !== outline_expect[0].outline_bit)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: outline_bit mismatch, expected %0b, actual %0b",
                                 $time, outline_expect[0].outline_bit, result.outline_bit);
                    end
                end
                if (result.last_of_frame !== outline_expect[0].last_of_frame)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: last_of_frame mismatch, expected %0b, actual %0b",
                                 $time, outline_expect[0].last_of_frame, result.last_of_frame);
                    end
                end
                void'(outline_expect.pop_front());
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, outline_expect.size());
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        frame_w_reg = 1;
        frame_h_reg = 1;
        clear_frame_position();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_after_reset();
        test_interior_pixel();
        test_size_extremes();
        test_random_frames();

        item_valid <= 1'b0;
        while (outline_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Streamed %0d frames (1x1 up to 512-pixel sides, some cut off) with %0d",
                 frames_done, effective_requests);
        $display("counted requests plus ignored ones; %0d outline results checked, %0d errors.",
                 results_checked, error_count);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule : tb_binary_outline_four_neighbor_unit

`default_nettype wire
